/* src/lpd_pkg.sv */
package lpd_pkg;

	// Fixed-point format and field widths
	localparam int FRAC_BITS     = 30;
	localparam int MAX_ORDER_DEF = 64;
	localparam int ORDER_IN_W    = 7;
	localparam int X_W           = 32;
	localparam int POLY_W        = 32;
	localparam int DERIV_W       = 47;
	localparam int QUO_W         = DERIV_W + 1;  // derivative quotient bits
	localparam int RCP_W         = 32;           // reciprocal table width

	localparam logic signed [POLY_W-1:0] ONE_FX = POLY_W'(64'd1 << FRAC_BITS);
	localparam logic signed [DERIV_W-1:0] DERIV_MAX = {1'b0, {(DERIV_W-1){1'b1}}};
	localparam logic signed [DERIV_W-1:0] DERIV_MIN = {1'b1, {(DERIV_W-1){1'b0}}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_MUL,
		ST_NUM,
		ST_DVA,
		ST_DVB,
		ST_FIX,
		ST_FXX,
		ST_FXY,
		ST_FNUM,
		ST_FCHK,
		ST_DIV,
		ST_DONE
	} lpd_state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic num;
		logic dva;
		logic dvb;
		logic fix;
		logic fxx;
		logic fxy;
		logic fnum;
		logic fchk;
		logic div;
		logic load_out;
	} lpd_cmd_t;

	typedef struct packed {
		logic n_zero;
		logic step_last;
		logic div_skip;
		logic div_last;
		logic out_free;
	} lpd_status_t;

endpackage

/* src/lpd_if.sv */
interface lpd_in_if
	import lpd_pkg::*;
();
	logic                   valid;
	logic                   ready;
	logic [ORDER_IN_W-1:0]  poly_order;
	logic signed [X_W-1:0]  point_x;

	modport source (output valid, poly_order, point_x, input ready);
	modport sink (input valid, poly_order, point_x, output ready);
endinterface

interface lpd_out_if
	import lpd_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic signed [POLY_W-1:0]  poly_value;
	logic signed [DERIV_W-1:0] deriv_value;
	logic                      deriv_ok;

	modport source (output valid, poly_value, deriv_value, deriv_ok, input ready);
	modport sink (input valid, poly_value, deriv_value, deriv_ok, output ready);
endinterface

/* src/legendre_poly_and_derivative_top.sv */
// Channel  Dir     Payload                                          Handshake
// operand  sink    poly_order[6:0], point_x[31:0] s (Q1.30)         valid/ready
// result   source  poly_value[31:0] s, deriv_value[46:0] s, deriv_ok valid/ready
//
// Each transaction runs from accept to next ready; order 0 skips the recurrence
//   and the divide, and |x| = 1 or a derivative overflow skips the divide.
// Each recurrence step runs the states MUL, NUM, DVA, DVB and FIX through the
//   shared 31x31 multiplier and the two-part reciprocal product; the derivative
//   takes a bit-serial divide.
// Reset: arst_n clears the controller and output valid; no clearing pass.
// Stalls: a finished result waits in the output register; a new operand is
//   taken meanwhile and only the final write-back waits on result.ready.
module legendre_poly_and_derivative_top
	import lpd_pkg::*;
#(
	parameter int MAX_ORDER = MAX_ORDER_DEF
) (
	input logic       clk,
	input logic       arst_n,
	lpd_in_if.sink    operand,
	lpd_out_if.source result
);

	lpd_cmd_t    cmd;
	lpd_status_t status;
	logic        op_ready;

	// sequencer: one operand at a time, steps the recurrence then the divide
	lpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (operand.valid),
		.op_ready (op_ready),
		.status   (status),
		.cmd      (cmd)
	);

	assign operand.ready = op_ready;

	// arithmetic, reciprocal table, divider and output register
	lpd_dpath #(
		.MAX_ORDER (MAX_ORDER)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.poly_order (operand.poly_order),
		.point_x    (operand.point_x),
		.result     (result)
	);

endmodule

/* src/lpd_ctrl.sv */
module lpd_ctrl
	import lpd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        op_valid,
	output logic        op_ready,
	input  lpd_status_t status,
	output lpd_cmd_t    cmd
);

	lpd_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (op_valid) state_nxt = ST_START;
			end
			ST_START: begin
				state_nxt = status.n_zero ? ST_DONE : ST_MUL;
			end
			ST_MUL:  state_nxt = ST_NUM;
			ST_NUM:  state_nxt = ST_DVA;
			ST_DVA:  state_nxt = ST_DVB;
			ST_DVB:  state_nxt = ST_FIX;
			ST_FIX: begin
				state_nxt = status.step_last ? ST_FXX : ST_MUL;
			end
			ST_FXX:  state_nxt = ST_FXY;
			ST_FXY:  state_nxt = ST_FNUM;
			ST_FNUM: state_nxt = ST_FCHK;
			ST_FCHK: begin
				state_nxt = status.div_skip ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				if (status.div_last) state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		op_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				op_ready = 1'b1;
				cmd.load = op_valid;
			end
			ST_START: ;
			ST_MUL:  cmd.mul  = 1'b1;
			ST_NUM:  cmd.num  = 1'b1;
			ST_DVA:  cmd.dva  = 1'b1;
			ST_DVB:  cmd.dvb  = 1'b1;
			ST_FIX:  cmd.fix  = 1'b1;
			ST_FXX:  cmd.fxx  = 1'b1;
			ST_FXY:  cmd.fxy  = 1'b1;
			ST_FNUM: cmd.fnum = 1'b1;
			ST_FCHK: cmd.fchk = 1'b1;
			ST_DIV:  cmd.div  = 1'b1;
			ST_DONE: cmd.load_out = status.out_free;
			default: ;
		endcase
	end

endmodule

/* src/lpd_dpath.sv */
module lpd_dpath
	import lpd_pkg::*;
#(
	parameter int MAX_ORDER = MAX_ORDER_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lpd_cmd_t              cmd,
	output lpd_status_t           status,
	input  logic [ORDER_IN_W-1:0] poly_order,
	input  logic signed [X_W-1:0] point_x,
	lpd_out_if.source             result
);

	localparam int ORDER_W = $clog2(MAX_ORDER + 1);
	localparam int ONE_W   = FRAC_BITS + 1;           // magnitude up to ONE
	localparam int RNUM_W  = FRAC_BITS + ORDER_W + 2; // recurrence numerator magnitude
	localparam int LO_W    = RNUM_W / 2;
	localparam int HI_W    = RNUM_W - LO_W;
	localparam int PR_W    = RNUM_W + RCP_W;
	localparam int SH_W    = $clog2(ORDER_W + 1);
	localparam int DNUM_W  = FRAC_BITS + 1 + ORDER_W; // derivative numerator magnitude
	localparam int DM_W    = FRAC_BITS + 1;
	localparam int QSHIFT  = QUO_W - FRAC_BITS;
	localparam int CNT_W   = $clog2(QUO_W);
	localparam int PJ_W    = POLY_W + ORDER_W + 1;

	// reciprocal table: floor(2^(31+L)/d), L = ceil(log2 d)
	logic [RCP_W-1:0] rcp_tab [0:MAX_ORDER];
	logic [SH_W-1:0]  sh_tab  [0:MAX_ORDER];

	for (genvar g = 0; g <= MAX_ORDER; g++) begin : g_rcp
		localparam int GD = (g == 0) ? 1 : g;
		localparam int GL = $clog2(GD);
		localparam longint unsigned GR = (64'd1 << (RCP_W - 1 + GL)) / GD;
		assign rcp_tab[g] = RCP_W'(GR);
		assign sh_tab[g]  = SH_W'(GL);
	end

	// control registers
	logic [ORDER_W-1:0] j_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;

	// working registers
	logic signed [X_W-1:0]    x_q;
	logic [ORDER_W-1:0]       n_q;
	logic signed [POLY_W-1:0] y_q, p2_q, t_q;
	logic signed [PJ_W-1:0]   pj_q;
	logic [RNUM_W-1:0]        rmag_q;
	logic                     rneg_q, rsat_q;
	logic [LO_W+RCP_W-1:0]    plo_q;
	logic [ONE_W-1:0]         q0_q;
	logic [DM_W-1:0]          dm_q, rem_q;
	logic                     ok_q;
	logic [DNUM_W-1:0]        dmag_q;
	logic                     dneg_q, ovf_q;
	logic [QUO_W-1:0]         dsh_q;
	logic signed [POLY_W-1:0]  poly_q;
	logic signed [DERIV_W-1:0] deriv_q;
	logic                      dok_q;

	// input clamps
	logic signed [X_W-1:0] x_cl;
	logic [ORDER_W-1:0]    n_cl;
	assign x_cl = (point_x > ONE_FX) ? ONE_FX : ((point_x < -ONE_FX) ? -ONE_FX : point_x);
	assign n_cl = (int'(poly_order) > MAX_ORDER) ? ORDER_W'(MAX_ORDER) : ORDER_W'(poly_order);

	// shared Q-format multiplier, sign-magnitude, truncates toward zero
	logic signed [POLY_W-1:0] mop, mul_pos, mul_res;
	logic [ONE_W-1:0]         ax, am, mres;
	logic [2*ONE_W-1:0]       mprod;
	logic                     mneg;
	assign mop     = cmd.fxx ? x_q : y_q;
	assign ax      = ONE_W'(x_q[X_W-1] ? -x_q : x_q);
	assign am      = ONE_W'(mop[POLY_W-1] ? -mop : mop);
	assign mprod   = ax * am;
	assign mres    = mprod[FRAC_BITS +: ONE_W];
	assign mneg    = x_q[X_W-1] ^ mop[POLY_W-1];
	assign mul_pos = signed'(POLY_W'(mres));
	assign mul_res = mneg ? -mul_pos : mul_pos;

	// recurrence numerator (2j+1) x P_j - j P_{j-1}
	logic signed [PJ_W-1:0]   pj_full;
	logic signed [RNUM_W:0]   rnum;
	assign pj_full = p2_q * $signed({1'b0, j_q});
	assign rnum    = t_q * $signed({1'b0, j_q, 1'b1}) - pj_q;

	// divide by j+1 through the reciprocal table, one correction step
	logic [ORDER_W-1:0]    dv;
	logic [RCP_W-1:0]      rcp;
	logic [SH_W-1:0]       rsh;
	logic [RNUM_W-1:0]     dlim, qd, rrem;
	logic [HI_W+RCP_W-1:0] phi;
	logic [PR_W-1:0]       rfull;
	logic [ONE_W-1:0]      qc, ymag;
	logic signed [POLY_W-1:0] ypos, ynew;
	assign dv    = j_q + ORDER_W'(1);
	assign rcp   = rcp_tab[dv];
	assign rsh   = sh_tab[dv];
	assign dlim  = (RNUM_W'(dv) << FRAC_BITS) + RNUM_W'(dv);
	assign phi   = rmag_q[RNUM_W-1:LO_W] * rcp;
	assign rfull = (PR_W'(phi) << LO_W) + PR_W'(plo_q);
	assign qd    = RNUM_W'(q0_q) * RNUM_W'(dv);
	assign rrem  = rmag_q - qd;
	assign qc    = q0_q + ONE_W'(rrem >= RNUM_W'(dv));
	assign ymag  = rsat_q ? ONE_W'(ONE_FX) : qc;
	assign ypos  = signed'(POLY_W'(ymag));
	assign ynew  = rneg_q ? -ypos : ypos;

	// derivative numerator n (x P_n - P_{n-1})
	logic signed [POLY_W:0]  ddiff;
	logic signed [DNUM_W:0]  dnum;
	assign ddiff = t_q - p2_q;
	assign dnum  = ddiff * $signed({1'b0, n_q});

	// bit-serial divide of dmag * 2^FRAC_BITS by |x^2 - 1|
	logic               ovf;
	logic [DM_W:0]      dsr;
	logic               dge;
	logic [DM_W:0]      dnext;
	assign ovf   = dmag_q >= {dm_q, QSHIFT'(0)};
	assign dsr   = {rem_q, dsh_q[QUO_W-1]};
	assign dge   = dsr >= (DM_W+1)'(dm_q);
	assign dnext = dge ? dsr - (DM_W+1)'(dm_q) : dsr;

	// result formatting
	logic                      qsat, dok;
	logic signed [DERIV_W-1:0] qpos, dval;
	assign qsat = ovf_q || (dsh_q[QUO_W-1:DERIV_W-1] != '0);
	assign qpos = signed'(DERIV_W'(dsh_q[DERIV_W-2:0]));
	always_comb begin
		dok  = 1'b1;
		dval = '0;
		if (n_q != '0) begin
			if (!ok_q) begin
				dok = 1'b0;
			end else if (!dneg_q) begin
				// denominator is negative: nonnegative numerator gives a negative slope
				dval = qsat ? DERIV_MIN : -qpos;
			end else begin
				dval = qsat ? DERIV_MAX : qpos;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q         <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) j_q <= '0;
			else if (cmd.fix) j_q <= dv;
			if (cmd.fchk) cnt_q <= '0;
			else if (cmd.div) cnt_q <= cnt_q + CNT_W'(1);
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q  <= x_cl;
			n_q  <= n_cl;
			y_q  <= ONE_FX;
			p2_q <= '0;
			ok_q <= 1'b1;
		end
		if (cmd.mul) begin
			t_q  <= mul_res;
			pj_q <= pj_full;
		end
		if (cmd.num) begin
			rmag_q <= RNUM_W'(rnum[RNUM_W] ? -rnum : rnum);
			rneg_q <= rnum[RNUM_W];
		end
		if (cmd.dva) begin
			rsat_q <= rmag_q >= dlim;
			plo_q  <= rmag_q[LO_W-1:0] * rcp;
		end
		if (cmd.dvb) q0_q <= ONE_W'(rfull >> (RCP_W - 1 + int'(rsh)));
		if (cmd.fix) begin
			p2_q <= y_q;
			y_q  <= ynew;
		end
		if (cmd.fxx) t_q <= mul_res;
		if (cmd.fxy) begin
			t_q  <= mul_res;
			dm_q <= DM_W'(ONE_FX - t_q);
			ok_q <= t_q != ONE_FX;
		end
		if (cmd.fnum) begin
			dmag_q <= DNUM_W'(dnum[DNUM_W] ? -dnum : dnum);
			dneg_q <= dnum[DNUM_W];
		end
		if (cmd.fchk) begin
			ovf_q <= ovf;
			rem_q <= DM_W'(dmag_q >> QSHIFT);
			dsh_q <= {dmag_q[QSHIFT-1:0], FRAC_BITS'(0)};
		end
		if (cmd.div) begin
			rem_q <= DM_W'(dnext);
			dsh_q <= {dsh_q[QUO_W-2:0], dge};
		end
		if (cmd.load_out) begin
			poly_q  <= y_q;
			deriv_q <= dval;
			dok_q   <= dok;
		end
	end

	assign status.n_zero    = n_q == '0;
	assign status.step_last = dv == n_q;
	assign status.div_skip  = !ok_q || ovf;
	assign status.div_last  = cnt_q == CNT_W'(QUO_W - 1);
	assign status.out_free  = !out_valid_q || result.ready;

	assign result.valid       = out_valid_q;
	assign result.poly_value  = poly_q;
	assign result.deriv_value = deriv_q;
	assign result.deriv_ok    = dok_q;

`ifndef SYNTHESIS
	a_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fix |=> (y_q <= ONE_FX) && (y_q >= -ONE_FX))
		else $error("recurrence value left [-1,1]");
	a_rcp_err: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fix && !rsat_q |-> rrem < (RNUM_W'(dv) << 1))
		else $error("reciprocal quotient off by more than one");
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div |-> rem_q < dm_q)
		else $error("divider remainder not below divisor");
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.deriv_ok |-> result.deriv_value == '0)
		else $error("invalid derivative not zero");
`endif

endmodule

/* sim/tb_legendre_poly_and_derivative_top.sv */
`timescale 1ns / 100ps

module tb_legendre_poly_and_derivative_top;
	import lpd_pkg::*;

	// One result transaction: P_n(x), P_n'(x) and the derivative-valid flag.
	typedef struct packed {
		logic signed [POLY_W-1:0]  value;
		logic signed [DERIV_W-1:0] deriv;
		logic                      deriv_ok;
	} leg_result_t;

	// Directed stimulus row. When typed is set, want holds the answer as read
	// straight off the math; otherwise the row goes through legendre_at().
	typedef struct packed {
		logic [ORDER_IN_W-1:0] order;
		logic signed [X_W-1:0] x;
		logic                  typed;
		leg_result_t           want;
	} dir_row_t;

	localparam int NUM_DIR         = 25;
	localparam int ITEMS_PER_PHASE = 385;
	localparam int HOLD_CYCLES     = 1500;
	localparam int DRAIN_CYCLES    = 400;      // longer than the slowest transaction
	localparam int CYCLE_LIMIT     = 4000000;

	localparam logic signed [X_W-1:0]     NEG_ONE   = -ONE_FX;
	localparam logic signed [X_W-1:0]     HALF      = ONE_FX >>> 1;
	localparam logic signed [DERIV_W-1:0] D_ONE     = DERIV_W'(64'd1 << FRAC_BITS);
	localparam leg_result_t               NO_RESULT = '0;

	localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
		// order zero: value one, derivative zero, valid, for any x
		'{7'd0,   32'sd0,          1'b1, '{ONE_FX, 47'sd0, 1'b1}},
		'{7'd0,   ONE_FX,          1'b1, '{ONE_FX, 47'sd0, 1'b1}},
		'{7'd0,   32'sh8000_0000,  1'b1, '{ONE_FX, 47'sd0, 1'b1}},
		// P1 = x, P1' = 1
		'{7'd1,   32'sd0,          1'b1, '{32'sd0, D_ONE, 1'b1}},
		// endpoints: derivative flagged invalid and zeroed, P_n(+-1) = (+-1)^n
		'{7'd1,   ONE_FX,          1'b1, '{ONE_FX, 47'sd0, 1'b0}},
		'{7'd1,   NEG_ONE,         1'b1, '{NEG_ONE, 47'sd0, 1'b0}},
		// P2(0) = -1/2, P2'(0) = 0
		'{7'd2,   32'sd0,          1'b1, '{-HALF, 47'sd0, 1'b1}},
		'{7'd2,   ONE_FX,          1'b1, '{ONE_FX, 47'sd0, 1'b0}},
		'{7'd3,   NEG_ONE,         1'b1, '{NEG_ONE, 47'sd0, 1'b0}},
		'{7'd64,  ONE_FX,          1'b1, '{ONE_FX, 47'sd0, 1'b0}},
		'{7'd64,  NEG_ONE,         1'b1, '{ONE_FX, 47'sd0, 1'b0}},
		// order above the maximum is capped
		'{7'd127, ONE_FX,          1'b1, '{ONE_FX, 47'sd0, 1'b0}},
		// x outside [-1,1] is clamped to the endpoint
		'{7'd5,   32'sh7FFF_FFFF,  1'b1, '{ONE_FX, 47'sd0, 1'b0}},
		'{7'd6,   32'sh8000_0000,  1'b1, '{ONE_FX, 47'sd0, 1'b0}},
		'{7'd7,   32'sh8000_0001,  1'b1, '{NEG_ONE, 47'sd0, 1'b0}},
		// from here on the predictor supplies the answer
		'{7'd1,   HALF,            1'b0, NO_RESULT},
		'{7'd2,   HALF,            1'b0, NO_RESULT},
		'{7'd64,  ONE_FX - 1,      1'b0, NO_RESULT},   // one LSB inside the endpoint
		'{7'd64,  NEG_ONE + 1,     1'b0, NO_RESULT},
		'{7'd64,  32'sd1,          1'b0, NO_RESULT},
		'{7'd127, -(ONE_FX / 3),   1'b0, NO_RESULT},
		'{7'd10,  32'sh3000_0000,  1'b0, NO_RESULT},
		'{7'd65,  32'sh0ABC_DEF0,  1'b0, NO_RESULT},
		'{7'd33,  -32'sd1,         1'b0, NO_RESULT},
		'{7'd2,   32'sh4000_0001,  1'b0, NO_RESULT}
	};

	logic clk;
	logic arst_n;

	lpd_in_if  operand_if ();
	lpd_out_if result_if ();

	legendre_poly_and_derivative_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.operand(operand_if),
		.result (result_if)
	);

	// Results still owed by the block, oldest first.
	leg_result_t pending_legendre [$];

	int send_idle_pct;   // chance per cycle that the operand side sits idle
	int stall_pct;       // chance per cycle that the result side stalls
	int hold_left;       // long result hold-off, counted down by the receiver
	int mismatches;
	int results_seen;
	int endpoint_seen;
	int saturated_seen;
	int operands_sent;
	longint cycle_count;

	// 12 ns clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// x*y / 2^FRAC_BITS, truncated toward zero. Both operands are at most one
	// in magnitude, so the product fits in 64 bits.
	function automatic longint fx_mul(longint a, longint b);
		longint p;
		p = ((a < 0 ? -a : a) * (b < 0 ? -b : b)) >>> FRAC_BITS;
		return ((a < 0) != (b < 0)) ? -p : p;
	endfunction

	// Bonnet recurrence for P_n(x), then P_n' = n (x P_n - P_{n-1}) / (x^2 - 1).
	// Wide intermediates keep the sums exact; SV signed division truncates
	// toward zero, matching the hardware.
	function automatic leg_result_t legendre_at(logic [ORDER_IN_W-1:0] order,
			logic signed [X_W-1:0] x_in);
		longint one_l, n, x, cur, prev, older, den, j;
		logic signed [127:0] acc, step, mag, den_m, quo, rem, frac, full, cap;
		logic neg;
		leg_result_t r;
		one_l = longint'(1) << FRAC_BITS;
		cap   = 128'sd1 <<< (DERIV_W - 1);
		n     = longint'(order);
		if (n > MAX_ORDER_DEF)
			n = MAX_ORDER_DEF;
		x = longint'(x_in);
		if (x > one_l)
			x = one_l;
		if (x < -one_l)
			x = -one_l;

		cur  = one_l;
		prev = 0;
		for (j = 0; j < n; j++) begin
			older = prev;
			prev  = cur;
			acc   = fx_mul(x, prev);
			acc   = acc * (2 * j + 1);
			step  = older;
			step  = step * j;
			acc   = (acc - step) / (j + 1);
			if (acc > one_l)
				cur = one_l;
			else if (acc < -one_l)
				cur = -one_l;
			else
				cur = longint'(acc);
		end

		r.value    = POLY_W'(cur);
		r.deriv    = '0;
		r.deriv_ok = 1'b1;
		if (n != 0) begin
			den = fx_mul(x, x) - one_l;
			if (den == 0) begin
				r.deriv_ok = 1'b0;
			end else begin
				acc   = fx_mul(x, cur) - prev;
				acc   = acc * n;
				neg   = (acc < 0);
				mag   = neg ? -acc : acc;
				den_m = (den < 0) ? -den : den;
				quo   = mag / den_m;
				rem   = mag % den_m;
				if (quo > cap)
					quo = cap;
				frac = (rem <<< FRAC_BITS) / den_m;
				full = (quo <<< FRAC_BITS) + frac;
				if (neg != (den < 0))
					full = -full;
				if (full > DERIV_MAX)
					full = DERIV_MAX;
				else if (full < DERIV_MIN)
					full = DERIV_MIN;
				r.deriv = DERIV_W'(full);
			end
		end
		return r;
	endfunction

	// Mostly small orders to keep the run short; some up to the max and a
	// tail above it to exercise the cap (and the top order bit).
	function automatic logic [ORDER_IN_W-1:0] pick_order();
		int sel;
		sel = $urandom_range(99);
		if (sel < 70)
			return ORDER_IN_W'($urandom_range(16));
		else if (sel < 90)
			return ORDER_IN_W'($urandom_range(64, 17));
		return ORDER_IN_W'($urandom_range(127, 65));
	endfunction

	function automatic logic signed [X_W-1:0] pick_point();
		int sel;
		logic signed [X_W-1:0] v;
		sel = $urandom_range(99);
		if (sel < 60)
			v = X_W'($urandom_range(32'h8000_0000)) - ONE_FX;     // anywhere in [-1,1]
		else if (sel < 70)
			v = $urandom;                                        // full range, clamps
		else if (sel < 82)
			v = ONE_FX - X_W'($urandom_range(4096));             // close to an endpoint
		else if (sel < 88)
			v = ONE_FX;
		else if (sel < 94)
			v = X_W'($urandom_range(1024));                      // close to zero
		else
			v = ONE_FX >>> $urandom_range(20, 1);
		if (sel >= 60 && sel < 70)
			return v;
		return $urandom_range(1) ? v : -v;
	endfunction

	// Offer one operand; called and returns at a falling edge. Valid is left
	// high so back-to-back transactions need no extra assignment.
	task automatic send_operand(input logic [ORDER_IN_W-1:0] order,
			input logic signed [X_W-1:0] x, input leg_result_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			operand_if.valid = 1'b0;
			@(negedge clk);
		end
		operand_if.valid      = 1'b1;
		operand_if.poly_order = order;
		operand_if.point_x    = x;
		@(posedge clk);
		while (!operand_if.ready)
			@(posedge clk);
		pending_legendre = {pending_legendre, want};
		operands_sent++;
		@(negedge clk);
	endtask

	// Stop offering and wait until every owed result is back.
	task automatic settle();
		operand_if.valid = 1'b0;
		while (pending_legendre.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Idle/stall knobs change at a rising edge so the falling-edge drivers see
	// them consistently.
	task automatic set_mode(input int idle_pct, input int stall);
		operand_if.valid = 1'b0;
		@(posedge clk);
		send_idle_pct = idle_pct;
		stall_pct     = stall;
		@(negedge clk);
	endtask

	// Result side: random stalls plus the long hold-off, driven at the falling edge.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			result_if.ready = 1'b0;
		end else begin
			result_if.ready = ($urandom_range(99) >= stall_pct);
		end
	end

	// Result checker: every accepted transaction is matched against the oldest
	// expectation, field by field.
	always @(posedge clk) begin
		leg_result_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (pending_legendre.size() == 0) begin
				$error("result transaction with nothing expected: value %0d deriv %0d ok %0b",
					result_if.poly_value, result_if.deriv_value, result_if.deriv_ok);
				mismatches++;
			end else begin
				want = pending_legendre.pop_front();
				results_seen++;
				if (result_if.poly_value !== want.value) begin
					$error("poly_value: expected %0d, got %0d", want.value,
						result_if.poly_value);
					mismatches++;
				end
				if (result_if.deriv_value !== want.deriv) begin
					$error("deriv_value: expected %0d, got %0d", want.deriv,
						result_if.deriv_value);
					mismatches++;
				end
				if (result_if.deriv_ok !== want.deriv_ok) begin
					$error("deriv_ok: expected %0b, got %0b", want.deriv_ok,
						result_if.deriv_ok);
					mismatches++;
				end
				if (!want.deriv_ok)
					endpoint_seen++;
				if (want.deriv == DERIV_MAX || want.deriv == DERIV_MIN)
					saturated_seen++;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycle_count,
				pending_legendre.size());
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		logic [ORDER_IN_W-1:0] order;
		logic signed [X_W-1:0] x;

		arst_n                = 1'b0;
		operand_if.valid      = 1'b0;
		operand_if.poly_order = '0;
		operand_if.point_x    = '0;
		result_if.ready       = 1'b0;
		send_idle_pct         = 0;
		stall_pct             = 0;
		hold_left             = 0;
		mismatches            = 0;
		results_seen          = 0;
		endpoint_seen         = 0;
		saturated_seen        = 0;
		operands_sent         = 0;
		cycle_count           = 0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table: order zero, endpoints, clamping of order and x,
		// and a few interior points including ones next to the endpoints.
		for (int i = 0; i < NUM_DIR; i++)
			send_operand(DIR_ROWS[i].order, DIR_ROWS[i].x,
				DIR_ROWS[i].typed ? DIR_ROWS[i].want :
				legendre_at(DIR_ROWS[i].order, DIR_ROWS[i].x));
		settle();

		// Random phases: no idling, idle sender, stalling receiver, both.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: set_mode(0, 0);
				1: set_mode(61, 0);
				2: set_mode(0, 61);
				default: set_mode(10, 10);
			endcase
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (ph == 0 && k == 120) begin
					// Long result hold-off while operands keep coming: the
					// output register and the datapath fill and input stalls.
					operand_if.valid = 1'b0;
					@(posedge clk);
					hold_left = HOLD_CYCLES;
					@(negedge clk);
				end
				if (ph == 3 && k == 200)
					settle();    // sender pause until the block is empty
				order = pick_order();
				x     = pick_point();
				send_operand(order, x, legendre_at(order, x));
			end
			settle();
		end

		// Nothing owed; give any stray result time to show up.
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d operand transactions (%0d directed), %0d results checked",
			operands_sent, NUM_DIR, results_seen);
		$display("  %0d at the endpoints, %0d with saturated derivative, %0d cycles",
			endpoint_seen, saturated_seen, cycle_count);
		if (mismatches == 0 && pending_legendre.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* sim.f */
src/lpd_pkg.sv
src/lpd_if.sv
src/lpd_ctrl.sv
src/lpd_dpath.sv
src/legendre_poly_and_derivative_top.sv
sim/tb_legendre_poly_and_derivative_top.sv
